// ----- rtl/lr_pkg.sv -----
// Shared types, constants and the coordinate clamp function for the line rasterizer.
// Used by lr_ctrl, lr_datapath and line_rasterizer_top; depends on nothing.
`default_nettype none

package lr_pkg;

    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 32;
    localparam int CANVAS_SIZE = 64;
    localparam int ERR_W       = COORD_W + 3;
    localparam int IN_FIELDS_W = 4 * COORD_W + COLOR_W;
    localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * COORD_W + COLOR_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(CANVAS_SIZE - 1);

    typedef struct packed {
        logic load;
        logic setup;
        logic step;
    } lr_cmd_t;

    typedef struct packed {
        logic last;
    } lr_sts_t;

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        clamp_coord = (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lr_ctrl.sv -----
// Line rasterizer controller: accept, setup and draw sequencing plus output valid.
// Depends on lr_pkg; drives lr_datapath through lr_cmd_t.
`default_nettype none

module lr_ctrl
    import lr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output lr_cmd_t      cmd,
    input  wire lr_sts_t sts
);

    typedef enum logic [1:0] {
        IDLE,
        SETUP,
        DRAW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = SETUP;
                end
            end
            SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = DRAW;
            end
            DRAW:
            begin
                if (out_free)
                begin
                    cmd.step       = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.last)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (!out_valid_reg || out_ready))
        else $error("pixel step while output register is occupied");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && sts.last) |=> (state_reg == IDLE))
        else $error("no return to idle after last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SETUP) |=> (state_reg == DRAW))
        else $error("setup not followed by draw");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> out_valid_reg)
        else $error("stepped pixel not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/lr_datapath.sv -----
// Line rasterizer datapath: endpoint clamp, axis swap and ordering, Bresenham step.
// Depends on lr_pkg; sequenced by lr_ctrl through lr_cmd_t.
`default_nettype none

module lr_datapath
    import lr_pkg::*;
(
    input  wire logic               clk,
    input  wire lr_cmd_t            cmd,
    output lr_sts_t                 sts,
    input  wire logic [COORD_W-1:0] start_x,
    input  wire logic [COORD_W-1:0] start_y,
    input  wire logic [COORD_W-1:0] end_x,
    input  wire logic [COORD_W-1:0] end_y,
    input  wire logic [COLOR_W-1:0] pen_color,
    output logic [COORD_W-1:0]      pixel_x,
    output logic [COORD_W-1:0]      pixel_y,
    output logic [COLOR_W-1:0]      pixel_color,
    output logic                    last_pixel
);

    logic [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [COLOR_W-1:0] color_reg;

    logic [COORD_W-1:0]     major_reg, minor_reg, end_major_reg, dx_reg, ady_reg;
    logic                   up_reg, steep_reg;
    logic signed [ERR_W-1:0] err_reg;

    logic [COORD_W-1:0] pix_x_reg, pix_y_reg;
    logic [COLOR_W-1:0] pix_color_reg;
    logic               last_reg;

    // setup
    logic [COORD_W-1:0] adx, ady0;
    logic               steep;
    logic [COORD_W-1:0] a_maj, a_min, b_maj, b_min;
    logic               swap;
    logic [COORD_W-1:0] o_amaj, o_amin, o_bmaj, o_bmin;
    logic               up;

    always_comb
    begin
        adx    = (sx_reg > ex_reg) ? (sx_reg - ex_reg) : (ex_reg - sx_reg);
        ady0   = (sy_reg > ey_reg) ? (sy_reg - ey_reg) : (ey_reg - sy_reg);
        steep  = ady0 > adx;
        a_maj  = steep ? sy_reg : sx_reg;
        a_min  = steep ? sx_reg : sy_reg;
        b_maj  = steep ? ey_reg : ex_reg;
        b_min  = steep ? ex_reg : ey_reg;
        swap   = a_maj > b_maj;
        o_amaj = swap ? b_maj : a_maj;
        o_amin = swap ? b_min : a_min;
        o_bmaj = swap ? a_maj : b_maj;
        o_bmin = swap ? a_min : b_min;
        up     = o_bmin > o_amin;
    end

    // step
    logic signed [ERR_W-1:0] err_mag, two_dx, two_ady, err_adj, err_next;
    logic                    bump;
    logic [COORD_W-1:0]      minor_next;

    always_comb
    begin
        err_mag    = err_reg[ERR_W-1] ? -err_reg : err_reg;
        two_dx     = $signed({2'b00, dx_reg, 1'b0});
        two_ady    = $signed({2'b00, ady_reg, 1'b0});
        bump       = err_mag > $signed({3'b000, dx_reg});
        minor_next = bump ? (up_reg ? minor_reg + COORD_W'(1) : minor_reg - COORD_W'(1))
                          : minor_reg;
        err_adj    = bump ? (err_reg - two_dx) : err_reg;
        err_next   = err_adj + two_ady;
    end

    assign sts.last = (major_reg == end_major_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sx_reg    <= clamp_coord(start_x);
            sy_reg    <= clamp_coord(start_y);
            ex_reg    <= clamp_coord(end_x);
            ey_reg    <= clamp_coord(end_y);
            color_reg <= pen_color;
        end
        if (cmd.setup)
        begin
            steep_reg     <= steep;
            major_reg     <= o_amaj;
            minor_reg     <= o_amin;
            end_major_reg <= o_bmaj;
            dx_reg        <= o_bmaj - o_amaj;
            ady_reg       <= up ? (o_bmin - o_amin) : (o_amin - o_bmin);
            up_reg        <= up;
            err_reg       <= '0;
        end
        if (cmd.step)
        begin
            pix_x_reg     <= steep_reg ? minor_next : major_reg;
            pix_y_reg     <= steep_reg ? major_reg : minor_next;
            pix_color_reg <= color_reg;
            last_reg      <= sts.last;
            minor_reg     <= minor_next;
            major_reg     <= major_reg + COORD_W'(1);
            err_reg       <= err_next;
        end
    end

    assign pixel_x     = pix_x_reg;
    assign pixel_y     = pix_y_reg;
    assign pixel_color = pix_color_reg;
    assign last_pixel  = last_reg;

endmodule

`default_nettype wire

// ----- rtl/line_rasterizer_top.sv -----
// Line rasterizer top level: stream ports around lr_ctrl and lr_datapath.
// Depends on lr_pkg, lr_ctrl and lr_datapath.
//
// Usage:
//   Slave side takes one line segment per item: two endpoints and a pen color.
//   Coordinates of CANVAS_SIZE or more are saturated to CANVAS_SIZE-1.
//   Master side emits one pixel per item in rising order of the major axis;
//   tlast marks the final pixel of each line.
// Timing:
//   s_tready is high only while no line is in progress. The accepting edge
//   loads the segment, the next cycle sets up the line, and in the draw state
//   the first pixel is stepped into the output register once that is free.
//   Pixels then follow one per cycle while m_tready does not hold them, set by
//   the single step unit. A line has N pixels (N = max(|dx|,|dy|)+1, 1 to 64).
//   The next line is accepted while the last pixel of the previous one still
//   waits in the output register.
// Reset and stall:
//   rst_n clears the sequencer and the output valid; any line in progress is
//   dropped. When m_tready is low the pixel holds and stepping pauses.
`default_nettype none

module line_rasterizer_top
    import lr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // start_x, start_y, end_x, end_y, pen_color from bit 0 up; no pad bits
    input  wire logic [IN_TDATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [OUT_TDATA_W-1:0]     m_tdata,
    output logic                       m_tlast
);

    lr_cmd_t            cmd;
    lr_sts_t            sts;
    logic [COORD_W-1:0] pixel_x, pixel_y;
    logic [COLOR_W-1:0] pixel_color;

    lr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lr_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .sts         (sts),
        .start_x     (s_tdata[COORD_W-1:0]),
        .start_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .end_x       (s_tdata[3*COORD_W-1:2*COORD_W]),
        .end_y       (s_tdata[4*COORD_W-1:3*COORD_W]),
        .pen_color   (s_tdata[IN_FIELDS_W-1:4*COORD_W]),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, pixel_color, pixel_y, pixel_x};

endmodule

`default_nettype wire
